// ===== src/csfw_pkg.sv =====
// Shared types and constants for the counting semaphore with FIFO waiters.
// Used by the controller, the datapath and the top level; no dependencies.
package csfw_pkg;

    // Request kinds carried on the input tuser bit.
    localparam logic FUNC_CAPTURE = 1'b0;
    localparam logic FUNC_RELEASE = 1'b1;

    // Result word layout, lowest bit first.
    localparam int OUT_HELD_BIT  = 0;
    localparam int OUT_GRANT_BIT = 1;
    localparam int OUT_QUEUE_BIT = 2;
    localparam int OUT_WOKEN_BIT = 3;
    localparam int OUT_WID_LSB   = 4;
    localparam int OUT_OVF_BIT   = 12;
    localparam int OUT_W         = 16;

    localparam int TID_W   = 8;
    localparam int LIMIT_W = 4;

    // Controller to datapath commands.
    typedef struct packed {
        logic load;    // capture the request and compare it against the holders
        logic commit;  // apply the request and load the result register
    } t_ctrl_cmd;

    // Datapath to controller status.
    typedef struct packed {
        logic out_free; // result register can take a new result this cycle
    } t_dp_status;

endpackage

// ===== src/csfw_ram.sv =====
// Generic simple dual-port RAM with one write port and a registered read port.
// Standalone; no package dependencies.
module csfw_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 8
) (
    input  logic                                  i_clk,
    input  logic                                  i_we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_waddr,
    input  logic [WIDTH-1:0]                      i_wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] i_raddr,
    output logic [WIDTH-1:0]                      o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== src/csfw_ctrl.sv =====
// Controller state machine: accepts one request, then sequences its execute step.
// Depends on csfw_pkg for the command and status types.
module csfw_ctrl (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_in_valid,
    output logic                  o_in_ready,
    input  csfw_pkg::t_dp_status  i_status,
    output csfw_pkg::t_ctrl_cmd   o_cmd
);
    import csfw_pkg::*;

    typedef enum logic [0:0] {
        S_IDLE,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_in_ready;

    // Commands are decoded combinationally from the registered state and ready, the
    // input valid and the status, so the datapath sees load in the same cycle as the handshake.
    always_comb begin
        o_cmd.load   = i_in_valid && r_in_ready;
        o_cmd.commit = (r_state == S_EXEC) && i_status.out_free;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= S_IDLE;
            r_in_ready <= 1'b1;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_in_valid && r_in_ready) begin
                        r_state    <= S_EXEC;
                        r_in_ready <= 1'b0;
                    end
                end
                S_EXEC: begin
                    if (i_status.out_free) begin
                        r_state    <= S_IDLE;
                        r_in_ready <= 1'b1;
                    end
                end
                default: begin
                    r_state    <= S_IDLE;
                    r_in_ready <= 1'b1;
                end
            endcase
        end
    end

    assign o_in_ready = r_in_ready;

endmodule

// ===== src/csfw_dp.sv =====
// Datapath: holder list in flip-flops, wait FIFO in RAM, result register.
// Depends on csfw_pkg and csfw_ram.
module csfw_dp #(
    parameter int HOLDER_SLOTS = 8,
    parameter int WAIT_DEPTH   = 8
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  csfw_pkg::t_ctrl_cmd           i_cmd,
    output csfw_pkg::t_dp_status          o_status,
    input  logic                          i_func,
    input  logic [csfw_pkg::TID_W-1:0]    i_tid,
    input  logic [csfw_pkg::LIMIT_W-1:0]  i_max_holders,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [csfw_pkg::OUT_W-1:0]    o_out_data
);
    import csfw_pkg::*;

    localparam int CW  = $clog2(HOLDER_SLOTS + 1);
    localparam int LW  = (CW > LIMIT_W) ? CW : LIMIT_W;
    localparam int WCW = $clog2(WAIT_DEPTH + 1);
    localparam int AW  = (WAIT_DEPTH > 1) ? $clog2(WAIT_DEPTH) : 1;

    logic [TID_W-1:0]        r_holder [HOLDER_SLOTS];
    logic [TID_W-1:0]        n_holder [HOLDER_SLOTS];
    logic [CW-1:0]           r_hcount, n_hcount;
    logic [HOLDER_SLOTS-1:0] r_match;
    logic                    r_func;
    logic [TID_W-1:0]        r_tid;
    logic [AW-1:0]           r_head, r_tail;
    logic [WCW-1:0]          r_wcount, n_wcount;
    logic                    r_out_valid;
    logic [OUT_W-1:0]        r_out_data, n_out_data;

    logic [HOLDER_SLOTS-1:0] from_pos;
    logic [CW-1:0]           limit;
    logic [CW-1:0]           cnt_dec;
    logic                    found, is_cap, rel, grant, queue, ovf, wake;
    logic [TID_W-1:0]        rd_data, woken_id;

    // Parallel compare of the incoming id against the valid holder entries.
    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_func <= i_func;
            r_tid  <= i_tid;
            for (int i = 0; i < HOLDER_SLOTS; i++) begin
                r_match[i] <= (CW'(i) < r_hcount) && (r_holder[i] == i_tid);
            end
        end
    end

    always_comb begin
        from_pos[0] = r_match[0];
        for (int i = 1; i < HOLDER_SLOTS; i++) begin
            from_pos[i] = from_pos[i-1] | r_match[i];
        end
    end

    assign limit   = (LW'(i_max_holders) < LW'(HOLDER_SLOTS)) ? CW'(i_max_holders)
                                                             : CW'(HOLDER_SLOTS);
    assign found   = |r_match;
    assign is_cap  = (r_func == FUNC_CAPTURE);
    assign grant   = is_cap && (r_hcount < limit);
    assign queue   = is_cap && !grant && (r_wcount < WCW'(WAIT_DEPTH));
    assign ovf     = is_cap && !grant && !queue;
    assign rel     = (r_func == FUNC_RELEASE) && found;
    assign cnt_dec = r_hcount - CW'(1);
    assign wake    = rel && (cnt_dec < limit) && (r_wcount != '0);
    assign woken_id = wake ? rd_data : '0;

    // Next holder entries: append on grant, close the gap on release, and put
    // a promoted waiter into the slot freed at the end of the list.
    for (genvar j = 0; j < HOLDER_SLOTS; j++) begin : g_slot
        logic [TID_W-1:0] up;
        if (j < HOLDER_SLOTS - 1) begin : g_up
            assign up = r_holder[j+1];
        end else begin : g_last
            assign up = r_holder[j];
        end
        always_comb begin
            n_holder[j] = r_holder[j];
            if (grant && (CW'(j) == r_hcount)) begin
                n_holder[j] = r_tid;
            end
            if (rel && from_pos[j]) begin
                n_holder[j] = up;
            end
            if (wake && (CW'(j) == cnt_dec)) begin
                n_holder[j] = rd_data;
            end
        end
    end

    always_comb begin
        n_hcount = r_hcount;
        if (grant) begin
            n_hcount = r_hcount + CW'(1);
        end else if (rel && !wake) begin
            n_hcount = cnt_dec;
        end
        n_wcount = r_wcount;
        if (queue) begin
            n_wcount = r_wcount + WCW'(1);
        end else if (wake) begin
            n_wcount = r_wcount - WCW'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            for (int i = 0; i < HOLDER_SLOTS; i++) begin
                r_holder[i] <= n_holder[i];
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_hcount <= '0;
            r_wcount <= '0;
            r_head   <= '0;
            r_tail   <= '0;
        end else if (i_cmd.commit) begin
            r_hcount <= n_hcount;
            r_wcount <= n_wcount;
            if (queue) begin
                r_tail <= (r_tail == AW'(WAIT_DEPTH - 1)) ? '0 : r_tail + AW'(1);
            end
            if (wake) begin
                r_head <= (r_head == AW'(WAIT_DEPTH - 1)) ? '0 : r_head + AW'(1);
            end
        end
    end

    csfw_ram #(
        .WIDTH (TID_W),
        .DEPTH (WAIT_DEPTH)
    ) u_wait_ram (
        .i_clk   (i_clk),
        .i_we    (i_cmd.commit && queue),
        .i_waddr (r_tail),
        .i_wdata (r_tid),
        .i_raddr (r_head),
        .o_rdata (rd_data)
    );

    // Result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (i_cmd.commit) begin
            r_out_valid <= 1'b1;
        end else if (i_out_ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_comb begin
        n_out_data                       = '0;
        n_out_data[OUT_HELD_BIT]         = found;
        n_out_data[OUT_GRANT_BIT]        = grant;
        n_out_data[OUT_QUEUE_BIT]        = queue;
        n_out_data[OUT_WOKEN_BIT]        = wake;
        n_out_data[OUT_WID_LSB +: TID_W] = woken_id;
        n_out_data[OUT_OVF_BIT]          = ovf;
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.commit) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_status.out_free = !r_out_valid || i_out_ready;
    assign o_out_valid       = r_out_valid;
    assign o_out_data        = r_out_data;

endmodule

// ===== src/counting_semaphore_fifo_waiters_top.sv =====
// Counting semaphore with a FIFO of waiting threads: top level.
// A request is captured on its transfer; no new request is accepted until its
// execute step, which waits for a free result register, has compacted the holder
// list, updated the wait FIFO and loaded the result register.
// Reset (i_rst_n, synchronous, active low) clears the counts, FIFO pointers
// and the limit (to 1); holder and FIFO storage is not cleared.
module counting_semaphore_fifo_waiters_top #(
    parameter int HOLDER_SLOTS = 8,
    parameter int WAIT_DEPTH   = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Request channel.
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [7:0]  s_tdata,   // [7:0] thread_id
    input  logic [0:0]  s_tuser,   // [0] func (0 capture, 1 release)
    // Result channel.
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [15:0] m_tdata,   // [0] held_before, [1] granted, [2] queued,
                                   // [3] woken_valid, [11:4] woken_thread,
                                   // [12] overflow, [15:13] zero
    // Limit register write port.
    input  logic        i_cfg_we,
    input  logic [3:0]  i_cfg_wdata
);
    import csfw_pkg::*;

    t_ctrl_cmd          cmd;
    t_dp_status         status;
    logic [LIMIT_W-1:0] r_max_holders;

    // The user must see that the limit is only written while no request is in
    // flight (the block does not enforce it), so the datapath reads it directly.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_max_holders <= LIMIT_W'(1);
        end else if (i_cfg_we) begin
            r_max_holders <= i_cfg_wdata;
        end
    end

    csfw_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_tvalid),
        .o_in_ready (s_tready),
        .i_status   (status),
        .o_cmd      (cmd)
    );

    csfw_dp #(
        .HOLDER_SLOTS (HOLDER_SLOTS),
        .WAIT_DEPTH   (WAIT_DEPTH)
    ) u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_status      (status),
        .i_func        (s_tuser[0]),
        .i_tid         (s_tdata),
        .i_max_holders (r_max_holders),
        .o_out_valid   (m_tvalid),
        .i_out_ready   (m_tready),
        .o_out_data    (m_tdata)
    );

    // A request transfer is always followed by a cycle with ready low.
    a_one_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("request accepted while another was executing");

    // At most one outcome per result.
    a_one_outcome: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_tvalid |-> $onehot0({m_tdata[OUT_GRANT_BIT], m_tdata[OUT_QUEUE_BIT],
                               m_tdata[OUT_WOKEN_BIT], m_tdata[OUT_OVF_BIT]}))
        else $error("result reports more than one outcome");

    // The woken id is zero unless a waiter was promoted.
    a_woken_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_tvalid && !m_tdata[OUT_WOKEN_BIT]) |-> (m_tdata[11:4] == '0))
        else $error("woken id set without a promotion");

    // A commit never overwrites a result that has not been taken.
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.commit |-> (!m_tvalid || m_tready))
        else $error("result register overwritten");

endmodule

// ===== bench/counting_semaphore_fifo_waiters_top_test.sv =====
// Self-checking bench for the counting semaphore with a FIFO of waiting threads.
// Drives capture and release requests; checks results against the table or a predictor.
// Depends on csfw_pkg and counting_semaphore_fifo_waiters_top only.
module counting_semaphore_fifo_waiters_top_test;

    import csfw_pkg::*;

    localparam int HOLDER_SLOTS = 8;
    localparam int WAIT_DEPTH   = 8;
    // Cycles without any transfer before the run is declared hung. The longest
    // idle stretch of a correct run is a long source gap plus a long sink stall.
    localparam int STUCK_LIMIT  = 2000;
    localparam int PHASES       = 10;
    localparam int PHASE_ITEMS  = 108;
    localparam int POOL_SIZE    = 16;

    // One expected result, field by field.
    typedef struct packed {
        logic       held_before;
        logic       granted;
        logic       queued;
        logic       woken_valid;
        logic [7:0] woken_thread;
        logic       overflow;
    } t_sem_result;

    localparam t_sem_result R_NONE  = '0;
    localparam t_sem_result R_GRANT = '{granted: 1'b1, default: '0};
    localparam t_sem_result R_QUEUE = '{queued: 1'b1, default: '0};
    localparam t_sem_result R_DUP_QUEUE = '{held_before: 1'b1, queued: 1'b1, default: '0};
    localparam t_sem_result R_OVF   = '{overflow: 1'b1, default: '0};
    localparam t_sem_result R_HELD  = '{held_before: 1'b1, default: '0};
    localparam t_sem_result R_WAKE_00 =
        '{held_before: 1'b1, woken_valid: 1'b1, woken_thread: 8'h00, default: '0};
    localparam t_sem_result R_WAKE_FF =
        '{held_before: 1'b1, woken_valid: 1'b1, woken_thread: 8'hFF, default: '0};

    // A row of the directed table: an optional limit write before the request,
    // the request itself, and a hand-typed result where one is obvious.
    typedef struct packed {
        logic        set_lim;
        logic [3:0]  lim;
        logic        func;
        logic [7:0]  tid;
        logic        typed;
        t_sem_result want;
    } t_plan_row;

    localparam int PLAN_ROWS = 25;
    localparam t_plan_row DIRECTED_PLAN [PLAN_ROWS] = '{
        '{1'b0, 4'd0,  FUNC_RELEASE, 8'h00, 1'b1, R_NONE},    // release by a non-holder
        '{1'b0, 4'd0,  FUNC_CAPTURE, 8'h00, 1'b1, R_GRANT},   // first holder under limit 1
        '{1'b0, 4'd0,  FUNC_CAPTURE, 8'h00, 1'b1, R_DUP_QUEUE}, // duplicate capture waits
        '{1'b0, 4'd0,  FUNC_CAPTURE, 8'hFF, 1'b1, R_QUEUE},
        '{1'b0, 4'd0,  FUNC_RELEASE, 8'h00, 1'b1, R_WAKE_00}, // wakes its own duplicate
        '{1'b0, 4'd0,  FUNC_RELEASE, 8'h00, 1'b1, R_WAKE_FF},
        '{1'b0, 4'd0,  FUNC_RELEASE, 8'hFF, 1'b1, R_HELD},    // nobody left waiting
        '{1'b0, 4'd0,  FUNC_CAPTURE, 8'hA5, 1'b1, R_GRANT},
        '{1'b0, 4'd0,  FUNC_CAPTURE, 8'h5A, 1'b1, R_QUEUE},   // fill the wait FIFO
        '{1'b0, 4'd0,  FUNC_CAPTURE, 8'h01, 1'b1, R_QUEUE},
        '{1'b0, 4'd0,  FUNC_CAPTURE, 8'h02, 1'b1, R_QUEUE},
        '{1'b0, 4'd0,  FUNC_CAPTURE, 8'h04, 1'b1, R_QUEUE},
        '{1'b0, 4'd0,  FUNC_CAPTURE, 8'h08, 1'b1, R_QUEUE},
        '{1'b0, 4'd0,  FUNC_CAPTURE, 8'h10, 1'b1, R_QUEUE},
        '{1'b0, 4'd0,  FUNC_CAPTURE, 8'h20, 1'b1, R_QUEUE},
        '{1'b0, 4'd0,  FUNC_CAPTURE, 8'h40, 1'b1, R_QUEUE},
        '{1'b0, 4'd0,  FUNC_CAPTURE, 8'h80, 1'b1, R_OVF},     // full FIFO drops it
        '{1'b1, 4'd0,  FUNC_RELEASE, 8'hA5, 1'b1, R_HELD},    // limit zero: no promotion
        '{1'b0, 4'd0,  FUNC_CAPTURE, 8'h33, 1'b1, R_OVF},
        '{1'b1, 4'd15, FUNC_CAPTURE, 8'h5A, 1'b1, R_GRANT},   // limit above the slots
        '{1'b0, 4'd0,  FUNC_RELEASE, 8'h5A, 1'b0, R_NONE},
        '{1'b0, 4'd0,  FUNC_CAPTURE, 8'h11, 1'b0, R_NONE},
        '{1'b0, 4'd0,  FUNC_CAPTURE, 8'h22, 1'b0, R_NONE},
        '{1'b1, 4'd1,  FUNC_RELEASE, 8'h11, 1'b0, R_NONE},    // limit now below the count
        '{1'b0, 4'd0,  FUNC_CAPTURE, 8'hC3, 1'b0, R_NONE}
    };

    // Limits used by the random phases; the ninth is drawn at random.
    localparam logic [3:0] LIMIT_PLAN [PHASES] =
        '{4'd8, 4'd2, 4'd0, 4'd15, 4'd1, 4'd5, 4'd8, 4'd3, 4'd0, 4'd7};

    logic        i_clk;
    logic        i_rst_n     = 1'b0;
    logic        s_tvalid    = 1'b0;
    logic        s_tready;
    logic [7:0]  s_tdata     = '0;   // [7:0] thread_id
    logic [0:0]  s_tuser     = '0;   // [0] func
    logic        m_tvalid;
    logic        m_tready    = 1'b0;
    logic [15:0] m_tdata;            // [0] held_before, [1] granted, [2] queued,
                                     // [3] woken_valid, [11:4] woken_thread,
                                     // [12] overflow
    logic        i_cfg_we    = 1'b0;
    logic [3:0]  i_cfg_wdata = '0;

    // Predictor state: holder list in order of entry and a circular wait FIFO.
    logic [3:0]  limit_reg;
    logic [7:0]  holder_ids [HOLDER_SLOTS];
    int          holder_cnt;
    logic [7:0]  waiter_ids [WAIT_DEPTH];
    int          waiter_head;
    int          waiter_cnt;

    t_sem_result due_outcomes [$];

    int failures     = 0;
    int stuck_cycles = 0;
    int sink_hold    = 0;
    bit sink_steady  = 1'b0;
    bit src_steady   = 1'b0;

    int n_sent, n_settings, n_granted, n_queued, n_woken, n_overflow, n_stray;

    counting_semaphore_fifo_waiters_top #(
        .HOLDER_SLOTS (HOLDER_SLOTS),
        .WAIT_DEPTH   (WAIT_DEPTH)
    ) DUT (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tuser     (s_tuser),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata)
    );

    initial begin
        i_clk = 1'b0;
        forever #4 i_clk = ~i_clk;
    end

    // Applies one request to the predicted semaphore state and returns the result
    // it should produce. The effective limit never exceeds the number of slots.
    function automatic t_sem_result predict_request(logic func, logic [7:0] tid);
        t_sem_result r;
        int pos;
        int lim_eff;
        r = '0;
        pos = -1;
        lim_eff = (int'(limit_reg) < HOLDER_SLOTS) ? int'(limit_reg) : HOLDER_SLOTS;
        for (int i = 0; i < holder_cnt; i++) begin
            if (pos < 0 && holder_ids[i] == tid) pos = i;
        end
        r.held_before = (pos >= 0);
        if (func == FUNC_CAPTURE) begin
            if (holder_cnt < lim_eff) begin
                holder_ids[holder_cnt] = tid;
                holder_cnt++;
                r.granted = 1'b1;
            end else if (waiter_cnt < WAIT_DEPTH) begin
                waiter_ids[(waiter_head + waiter_cnt) % WAIT_DEPTH] = tid;
                waiter_cnt++;
                r.queued = 1'b1;
            end else begin
                r.overflow = 1'b1;
            end
        end else if (pos >= 0) begin
            // Close the gap left by the first matching entry.
            for (int i = pos; i + 1 < holder_cnt; i++) holder_ids[i] = holder_ids[i + 1];
            holder_cnt--;
            if (holder_cnt < lim_eff && waiter_cnt > 0) begin
                r.woken_thread = waiter_ids[waiter_head];
                r.woken_valid = 1'b1;
                waiter_head = (waiter_head + 1) % WAIT_DEPTH;
                waiter_cnt--;
                holder_ids[holder_cnt] = r.woken_thread;
                holder_cnt++;
            end
        end
        return r;
    endfunction

    function automatic void check_outcome(t_sem_result want, logic [OUT_W-1:0] word);
        if (word[OUT_HELD_BIT] !== want.held_before) begin
            $error("held_before: expected %0h, got %0h", want.held_before, word[OUT_HELD_BIT]);
            failures++;
        end
        if (word[OUT_GRANT_BIT] !== want.granted) begin
            $error("granted: expected %0h, got %0h", want.granted, word[OUT_GRANT_BIT]);
            failures++;
        end
        if (word[OUT_QUEUE_BIT] !== want.queued) begin
            $error("queued: expected %0h, got %0h", want.queued, word[OUT_QUEUE_BIT]);
            failures++;
        end
        if (word[OUT_WOKEN_BIT] !== want.woken_valid) begin
            $error("woken_valid: expected %0h, got %0h", want.woken_valid,
                   word[OUT_WOKEN_BIT]);
            failures++;
        end
        if (word[OUT_WID_LSB +: TID_W] !== want.woken_thread) begin
            $error("woken_thread: expected %0h, got %0h", want.woken_thread,
                   word[OUT_WID_LSB +: TID_W]);
            failures++;
        end
        if (word[OUT_OVF_BIT] !== want.overflow) begin
            $error("overflow: expected %0h, got %0h", want.overflow, word[OUT_OVF_BIT]);
            failures++;
        end
    endfunction

    // Source gap before a request: mostly none or short, now and then long.
    function automatic int pick_gap();
        int r;
        if (src_steady) return 0;
        r = $urandom_range(0, 99);
        if (r < 55) return 0;
        if (r < 92) return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Offers one request and waits for its transfer. tvalid is left high after
    // the transfer so that back-to-back requests keep it high without a dip.
    task automatic issue_request(input logic func, input logic [7:0] tid,
                                 input logic typed, input t_sem_result want);
        int gap;
        t_sem_result model;
        gap = pick_gap();
        if (gap > 0) begin
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= tid;
        s_tuser  <= func;
        do @(posedge i_clk); while (!s_tready);
        model = predict_request(func, tid);
        due_outcomes.push_back(typed ? want : model);
        n_sent++;
        n_granted  += model.granted;
        n_queued   += model.queued;
        n_woken    += model.woken_valid;
        n_overflow += model.overflow;
        if (func == FUNC_RELEASE && !model.held_before) n_stray++;
    endtask

    // The limit is only written once every outstanding result has been taken.
    task automatic set_limit(input logic [3:0] value);
        s_tvalid <= 1'b0;
        while (due_outcomes.size() != 0) @(posedge i_clk);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= value;
        @(posedge i_clk);
        i_cfg_we  <= 1'b0;
        limit_reg = value;
        n_settings++;
    endtask

    // Result sink: ready and stall stretches of random length, or always ready in steady phases.
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
        end else if (sink_steady) begin
            m_tready <= 1'b1;
        end else begin
            m_tready  <= ($urandom_range(0, 99) < 65);
            sink_hold <= ($urandom_range(0, 99) < 90) ? $urandom_range(0, 2)
                                                      : $urandom_range(10, 40);
        end
    end

    // Every result transfer is matched against the oldest expectation.
    always @(posedge i_clk) begin
        if (i_rst_n && m_tvalid && m_tready) begin
            if (due_outcomes.size() == 0) begin
                $error("result %h arrived with no request outstanding", m_tdata);
                failures++;
            end else begin
                check_outcome(due_outcomes.pop_front(), m_tdata);
            end
        end
    end

    // Watchdog on cycles in which neither channel moves a transfer and no limit is written.
    always @(posedge i_clk) begin
        if (!i_rst_n || i_cfg_we || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            stuck_cycles <= 0;
        end else if (stuck_cycles >= STUCK_LIMIT) begin
            $display("counting_semaphore_fifo_waiters_top_test: FAIL");
            $finish;
        end else begin
            stuck_cycles <= stuck_cycles + 1;
        end
    end

    initial begin
        logic       func;
        logic [7:0] tid;
        logic [7:0] id_pool [POOL_SIZE];
        int         r;

        limit_reg   = 4'd1;
        holder_cnt  = 0;
        waiter_head = 0;
        waiter_cnt  = 0;
        n_sent = 0; n_settings = 0; n_granted = 0; n_queued = 0;
        n_woken = 0; n_overflow = 0; n_stray = 0;

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part: reset state, duplicates, a full FIFO and the limit extremes.
        foreach (DIRECTED_PLAN[i]) begin
            if (DIRECTED_PLAN[i].set_lim) set_limit(DIRECTED_PLAN[i].lim);
            issue_request(DIRECTED_PLAN[i].func, DIRECTED_PLAN[i].tid,
                          DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].want);
        end

        // Random phases. The state carries over, so a lower limit often meets
        // more holders than it allows. Most releases come from real holders so
        // that waiters get promoted; the rest use pool ids that may not be held.
        for (int p = 0; p < PHASES; p++) begin
            set_limit(p == 8 ? 4'($urandom_range(0, 15)) : LIMIT_PLAN[p]);
            sink_steady = (p % 3 == 1);
            src_steady  = (p % 4 == 2);
            for (int k = 0; k < POOL_SIZE; k++) id_pool[k] = 8'($urandom_range(0, 255));
            for (int n = 0; n < PHASE_ITEMS; n++) begin
                r = $urandom_range(0, 99);
                if (holder_cnt > 0 && r < 40) begin
                    func = FUNC_RELEASE;
                    tid  = holder_ids[$urandom_range(0, holder_cnt - 1)];
                end else begin
                    func = (r < 50) ? FUNC_RELEASE : FUNC_CAPTURE;
                    tid  = ($urandom_range(0, 19) == 0) ? 8'($urandom_range(0, 255))
                                                        : id_pool[$urandom_range(0, POOL_SIZE - 1)];
                end
                issue_request(func, tid, 1'b0, R_NONE);
            end
        end

        sink_steady = 1'b0;
        s_tvalid <= 1'b0;
        while (due_outcomes.size() != 0) @(posedge i_clk);
        repeat (8) @(posedge i_clk);

        $display("Run covered %0d requests under %0d limit settings (%0d from the table).",
                 n_sent, n_settings, PLAN_ROWS);
        $display("Seen: %0d grants, %0d queued, %0d wake-ups, %0d overflows, %0d stray releases.",
                 n_granted, n_queued, n_woken, n_overflow, n_stray);
        if (failures == 0) begin
            $display("counting_semaphore_fifo_waiters_top_test: PASS");
        end else begin
            $display("counting_semaphore_fifo_waiters_top_test: FAIL");
        end
        $finish;
    end

endmodule
